// ===== rtl/pbkdf_pkg.sv =====
package pbkdf_pkg;

    // Buffer capacities in bytes.
    localparam int PW_CAP   = 1024;
    localparam int SALT_CAP = 1024;

    localparam int PW_AW   = $clog2(PW_CAP);
    localparam int SALT_AW = $clog2(SALT_CAP);
    localparam int PW_LW   = $clog2(PW_CAP + 1);
    localparam int SALT_LW = $clog2(SALT_CAP + 1);

    // Longest message that one hash pass sees, plus room for its padding.
    localparam int MSG_MAX = ((PW_CAP > SALT_CAP + 4) ? PW_CAP : SALT_CAP + 4) + 72;
    localparam int POS_W   = $clog2(MSG_MAX + 1);

    localparam int ITER_W  = 21;
    localparam int DKLEN_W = 11;
    localparam int BLK_W   = 5;
    localparam int NBLK_W  = 6;
    localparam int VB_W    = 6;
    localparam int CFG_W   = 21;

    localparam logic [ITER_W-1:0]  MAX_ITER  = ITER_W'(2000000);
    localparam logic [DKLEN_W-1:0] MAX_DKLEN = DKLEN_W'(1024);

    localparam logic [7:0] IPAD_BYTE = 8'h36;
    localparam logic [7:0] OPAD_BYTE = 8'h5C;

    localparam logic [1:0] OP_PW   = 2'd0;
    localparam logic [1:0] OP_SALT = 2'd1;
    localparam logic [1:0] OP_RUN  = 2'd2;

    localparam logic CFG_ITER  = 1'b0;
    localparam logic CFG_DKLEN = 1'b1;

    localparam logic [5:0] LAST_ROUND = 6'd63;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Which message the current hash pass is working on.
    typedef enum logic [2:0] {
        M_KEY    = 3'd0,
        M_IPAD   = 3'd1,
        M_OPAD   = 3'd2,
        M_INNER1 = 3'd3,
        M_INNERJ = 3'd4,
        M_OUTER  = 3'd5
    } t_mode;

    typedef struct packed {
        logic       pw_wr;
        logic       salt_wr;
        logic       run_init;
        logic       h_start;
        logic       push;
        logic       c_init;
        logic       c_round;
        logic [5:0] round;
        logic       c_add;
        logic       store;
        logic       acc_first;
        logic       emit;
        logic       emit_err;
        logic       blk_next;
        logic       clear;
        t_mode      mode;
    } t_cmd;

    typedef struct packed {
        logic              pw_long;
        logic              ovf;
        logic              blk_full;
        logic              msg_end;
        logic              last_blk;
        logic              out_free;
        logic [ITER_W-1:0] iters;
    } t_sts;

endpackage

// ===== rtl/pbkdf2_hmac_sha256_engine_core.sv =====
// PBKDF2 key derivation with HMAC-SHA-256.
// Input words carry an opcode and a data byte: opcode 0 appends a password
// byte, opcode 1 appends a salt byte, opcode 2 runs the derivation, and
// opcode 3 is dropped. A byte beyond a buffer's capacity is discarded and
// flagged, and the next run then returns a single error word (status 1,
// last 1) instead of a key.
// A run returns one output word per 32-byte block, in order, the last one
// trimmed to the derived key length. Both buffers clear when a run ends.
// Each SHA-256 compression loads its message bytes through an address state
// and a push state per byte, set by the registered read of the buffer
// memories, then runs its 64 rounds and adds the result into the chain; each
// hash pass also has a start state and a finish state. One HMAC iteration is
// two compressions, so a block costs about 2 * iteration_count compressions
// plus the salt's extra blocks. Key setup adds two compressions per run, and
// a password longer than 64 bytes costs two to seventeen more to hash it first.
// Input stall stays high while a run is in progress. A finished word sits in
// the output register until taken; while the receiver stalls, the engine
// holds there before writing the next block. The configuration channel is
// always ready; the user must write it only between runs (not enforced).
// Reset is synchronous: it empties both buffers, clears the flag, drops any
// pending output word and restores iteration_count 1 and key length 32.
module pbkdf2_hmac_sha256_engine_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_opcode,
    input  logic [7:0]                  i_data_byte,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_status,
    output logic [4:0]                  o_block_index,
    output logic [63:0]                 o_key_word0,
    output logic [63:0]                 o_key_word1,
    output logic [63:0]                 o_key_word2,
    output logic [63:0]                 o_key_word3,
    output logic [5:0]                  o_valid_bytes,
    output logic                        o_last,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [pbkdf_pkg::CFG_W-1:0] i_cfg_data
);

    // The controller sequences hash passes; the datapath owns the buffers, hash state and output.
    pbkdf_pkg::t_cmd cmd;
    pbkdf_pkg::t_sts sts;

    pbkdf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .o_stall  (o_stall),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    pbkdf_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_data_byte),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_block_index (o_block_index),
        .o_key_word0   (o_key_word0),
        .o_key_word1   (o_key_word1),
        .o_key_word2   (o_key_word2),
        .o_key_word3   (o_key_word3),
        .o_valid_bytes (o_valid_bytes),
        .o_last        (o_last)
    );

endmodule

// ===== rtl/pbkdf_ram.sv =====
module pbkdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pbkdf_ctrl.sv =====
module pbkdf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [1:0]       i_opcode,
    output logic             o_stall,
    input  pbkdf_pkg::t_sts  i_sts,
    output pbkdf_pkg::t_cmd  o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_PREP   = 10'b00_0000_0010,
        S_HSTART = 10'b00_0000_0100,
        S_ADDR   = 10'b00_0000_1000,
        S_PUSH   = 10'b00_0001_0000,
        S_CINIT  = 10'b00_0010_0000,
        S_ROUND  = 10'b00_0100_0000,
        S_CADD   = 10'b00_1000_0000,
        S_HDONE  = 10'b01_0000_0000,
        S_EMIT   = 10'b10_0000_0000
    } t_state;

    t_state                           r_state, n_state;
    pbkdf_pkg::t_mode                 r_mode, n_mode;
    logic [5:0]                       r_round, n_round;
    logic [pbkdf_pkg::ITER_W-1:0]     r_iter, n_iter;
    logic                             r_err, n_err;

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_round = r_round;
        n_iter  = r_iter;
        n_err   = r_err;
        o_cmd           = '0;
        o_cmd.mode      = r_mode;
        o_cmd.round     = r_round;
        o_cmd.acc_first = (r_iter == pbkdf_pkg::ITER_W'(1));
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    priority if (i_opcode == pbkdf_pkg::OP_PW) begin
                        o_cmd.pw_wr = 1'b1;
                    end else if (i_opcode == pbkdf_pkg::OP_SALT) begin
                        o_cmd.salt_wr = 1'b1;
                    end else if (i_opcode == pbkdf_pkg::OP_RUN) begin
                        if (i_sts.ovf) begin
                            n_err   = 1'b1;
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_PREP;
                        end
                    end else begin
                        // The unused opcode is taken and dropped.
                        n_state = S_IDLE;
                    end
                end
            end
            S_PREP: begin
                o_cmd.run_init = 1'b1;
                n_mode  = i_sts.pw_long ? pbkdf_pkg::M_KEY : pbkdf_pkg::M_IPAD;
                n_iter  = pbkdf_pkg::ITER_W'(1);
                n_err   = 1'b0;
                n_state = S_HSTART;
            end
            S_HSTART: begin
                o_cmd.h_start = 1'b1;
                n_state = S_ADDR;
            end
            S_ADDR: begin
                n_state = S_PUSH;
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state = i_sts.blk_full ? S_CINIT : S_ADDR;
            end
            S_CINIT: begin
                o_cmd.c_init = 1'b1;
                n_round = '0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.c_round = 1'b1;
                n_round = r_round + 6'd1;
                if (r_round == pbkdf_pkg::LAST_ROUND) begin
                    n_state = S_CADD;
                end
            end
            S_CADD: begin
                o_cmd.c_add = 1'b1;
                n_state = i_sts.msg_end ? S_HDONE : S_ADDR;
            end
            S_HDONE: begin
                o_cmd.store = 1'b1;
                n_state = S_HSTART;
                unique case (r_mode)
                    pbkdf_pkg::M_KEY:    n_mode = pbkdf_pkg::M_IPAD;
                    pbkdf_pkg::M_IPAD:   n_mode = pbkdf_pkg::M_OPAD;
                    pbkdf_pkg::M_OPAD:   n_mode = pbkdf_pkg::M_INNER1;
                    pbkdf_pkg::M_INNER1: n_mode = pbkdf_pkg::M_OUTER;
                    pbkdf_pkg::M_INNERJ: n_mode = pbkdf_pkg::M_OUTER;
                    pbkdf_pkg::M_OUTER: begin
                        if (r_iter == i_sts.iters) begin
                            n_state = S_EMIT;
                        end else begin
                            n_iter = r_iter + pbkdf_pkg::ITER_W'(1);
                            n_mode = pbkdf_pkg::M_INNERJ;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_err = r_err;
                    if (r_err || i_sts.last_blk) begin
                        o_cmd.clear = 1'b1;
                        n_err   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.blk_next = 1'b1;
                        n_iter  = pbkdf_pkg::ITER_W'(1);
                        n_mode  = pbkdf_pkg::M_INNER1;
                        n_state = S_HSTART;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= pbkdf_pkg::M_KEY;
            r_round <= '0;
            r_iter  <= pbkdf_pkg::ITER_W'(1);
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_round <= n_round;
            r_iter  <= n_iter;
            r_err   <= n_err;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    a_round_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_round == pbkdf_pkg::LAST_ROUND) |=> (r_state == S_CADD))
        else $error("compression did not finish after the last round");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("result written over a word still waiting");

    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HDONE) |-> (r_iter <= i_sts.iters))
        else $error("iteration counter ran past the iteration count");

endmodule

// ===== rtl/pbkdf_dpath.sv =====
module pbkdf_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_index,
    input  logic [pbkdf_pkg::CFG_W-1:0]     i_cfg_data,
    input  pbkdf_pkg::t_cmd                 i_cmd,
    output pbkdf_pkg::t_sts                 o_sts,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic                            o_status,
    output logic [4:0]                      o_block_index,
    output logic [63:0]                     o_key_word0,
    output logic [63:0]                     o_key_word1,
    output logic [63:0]                     o_key_word2,
    output logic [63:0]                     o_key_word3,
    output logic [5:0]                      o_valid_bytes,
    output logic                            o_last
);

    localparam int POS_W = pbkdf_pkg::POS_W;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    logic [pbkdf_pkg::ITER_W-1:0]  r_iter_cfg;
    logic [pbkdf_pkg::DKLEN_W-1:0] r_dklen_cfg;
    logic [pbkdf_pkg::PW_LW-1:0]   r_pw_len;
    logic [pbkdf_pkg::SALT_LW-1:0] r_salt_len;
    logic                          r_ovf;
    logic                          r_key_hashed;
    logic [pbkdf_pkg::BLK_W-1:0]   r_blk;
    logic [POS_W-1:0]              r_pos;

    logic [31:0]  r_chain     [8];
    logic [31:0]  r_inner_mid [8];
    logic [31:0]  r_outer_mid [8];
    logic [31:0]  r_u         [8];
    logic [31:0]  r_acc       [8];
    logic [31:0]  r_v         [8];
    logic [511:0] r_wv;

    logic        r_out_valid;
    logic        r_out_status;
    logic [4:0]  r_out_blk;
    logic [63:0] r_out_word [4];
    logic [5:0]  r_out_vb;
    logic        r_out_last;

    // Buffers.
    logic       pw_full, salt_full;
    logic [7:0] pw_rd, salt_rd;

    assign pw_full   = (r_pw_len == pbkdf_pkg::PW_LW'(pbkdf_pkg::PW_CAP));
    assign salt_full = (r_salt_len == pbkdf_pkg::SALT_LW'(pbkdf_pkg::SALT_CAP));

    pbkdf_ram #(.WIDTH(8), .DEPTH(pbkdf_pkg::PW_CAP)) u_pw_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.pw_wr && !pw_full),
        .i_waddr (r_pw_len[pbkdf_pkg::PW_AW-1:0]),
        .i_wdata (i_data_byte),
        .i_raddr (r_pos[pbkdf_pkg::PW_AW-1:0]),
        .o_rdata (pw_rd)
    );

    pbkdf_ram #(.WIDTH(8), .DEPTH(pbkdf_pkg::SALT_CAP)) u_salt_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.salt_wr && !salt_full),
        .i_waddr (r_salt_len[pbkdf_pkg::SALT_AW-1:0]),
        .i_wdata (i_data_byte),
        .i_raddr (r_pos[pbkdf_pkg::SALT_AW-1:0]),
        .o_rdata (salt_rd)
    );

    // Clamped configuration.
    logic [pbkdf_pkg::ITER_W-1:0]  iters;
    logic [pbkdf_pkg::DKLEN_W-1:0] dklen;
    logic [pbkdf_pkg::NBLK_W-1:0]  nblocks;
    logic [pbkdf_pkg::DKLEN_W:0]   dk_sum;
    logic [pbkdf_pkg::DKLEN_W-1:0] remain;
    logic                          last_blk;
    logic [pbkdf_pkg::VB_W-1:0]    vb;

    always_comb begin
        priority if (r_iter_cfg == '0) begin
            iters = pbkdf_pkg::ITER_W'(1);
        end else if (r_iter_cfg > pbkdf_pkg::MAX_ITER) begin
            iters = pbkdf_pkg::MAX_ITER;
        end else begin
            iters = r_iter_cfg;
        end
        priority if (r_dklen_cfg == '0) begin
            dklen = pbkdf_pkg::DKLEN_W'(1);
        end else if (r_dklen_cfg > pbkdf_pkg::MAX_DKLEN) begin
            dklen = pbkdf_pkg::MAX_DKLEN;
        end else begin
            dklen = r_dklen_cfg;
        end
    end

    assign dk_sum   = {1'b0, dklen} + (pbkdf_pkg::DKLEN_W + 1)'(31);
    assign nblocks  = pbkdf_pkg::NBLK_W'(dk_sum >> 5);
    assign last_blk = (({1'b0, r_blk} + pbkdf_pkg::NBLK_W'(1)) == nblocks);
    assign remain   = dklen - {1'b0, r_blk, 5'd0};
    assign vb       = last_blk ? remain[pbkdf_pkg::VB_W-1:0] : pbkdf_pkg::VB_W'(32);

    // Message bytes: message, 0x80, zeros, bit length; ipad/opad: key bytes only.
    logic [POS_W-1:0] msg_len, pad_sum, pad_len, end_pos, ctr_off;
    logic [POS_W:0]   tot_len;
    logic             pre64, pad_only;
    logic [63:0]      len_sh;
    logic [31:0]      u_word, u_sh;
    logic [7:0]       u_byte, key_byte, ctr_byte, msg_byte, push_byte;

    always_comb begin
        pre64    = 1'b1;
        pad_only = 1'b0;
        unique case (i_cmd.mode)
            pbkdf_pkg::M_KEY: begin
                msg_len = POS_W'(r_pw_len);
                pre64   = 1'b0;
            end
            pbkdf_pkg::M_IPAD, pbkdf_pkg::M_OPAD: begin
                msg_len  = POS_W'(64);
                pre64    = 1'b0;
                pad_only = 1'b1;
            end
            pbkdf_pkg::M_INNER1: msg_len = POS_W'(r_salt_len) + POS_W'(4);
            default:             msg_len = POS_W'(32);
        endcase
    end

    assign pad_sum = msg_len + POS_W'(72);
    assign pad_len = {pad_sum[POS_W-1:6], 6'd0};
    assign end_pos = pad_only ? POS_W'(64) : pad_len;
    assign tot_len = {1'b0, msg_len} + (pre64 ? (POS_W + 1)'(64) : '0);
    // The length field starts on a multiple of eight, so the low bits of the
    // position pick its byte.
    assign len_sh  = 64'({tot_len, 3'd0}) << {r_pos[2:0], 3'd0};

    assign u_word  = r_u[r_pos[4:2]];
    assign u_sh    = u_word << {r_pos[1:0], 3'd0};
    assign u_byte  = u_sh[31:24];

    always_comb begin
        if (r_key_hashed) begin
            key_byte = (r_pos < POS_W'(32)) ? u_byte : 8'h00;
        end else begin
            key_byte = (r_pos < POS_W'(r_pw_len)) ? pw_rd : 8'h00;
        end
    end

    assign ctr_off  = r_pos - POS_W'(r_salt_len);
    assign ctr_byte = (ctr_off[1:0] == 2'd3) ? (8'(r_blk) + 8'd1) : 8'h00;

    always_comb begin
        unique case (i_cmd.mode)
            pbkdf_pkg::M_KEY:    msg_byte = pw_rd;
            pbkdf_pkg::M_IPAD:   msg_byte = key_byte ^ pbkdf_pkg::IPAD_BYTE;
            pbkdf_pkg::M_OPAD:   msg_byte = key_byte ^ pbkdf_pkg::OPAD_BYTE;
            pbkdf_pkg::M_INNER1: msg_byte = (r_pos < POS_W'(r_salt_len)) ? salt_rd : ctr_byte;
            default:             msg_byte = u_byte;
        endcase
        priority if (r_pos < msg_len) begin
            push_byte = msg_byte;
        end else if (r_pos == msg_len) begin
            push_byte = 8'h80;
        end else if (r_pos >= pad_len - POS_W'(8)) begin
            push_byte = len_sh[63:56];
        end else begin
            push_byte = 8'h00;
        end
    end

    // One compression round.
    logic [31:0] w0, w1, w9, w14, new_w, t1, t2, ch, maj;

    assign w0    = r_wv[511:480];
    assign w1    = r_wv[479:448];
    assign w9    = r_wv[223:192];
    assign w14   = r_wv[63:32];
    assign new_w = ssig1(w14) + w9 + ssig0(w1) + w0;
    assign ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1    = r_v[7] + bsig1(r_v[4]) + ch + pbkdf_pkg::SHA_K[i_cmd.round] + w0;
    assign t2    = bsig0(r_v[0]) + maj;

    // Trimmed result block.
    logic [255:0] acc_vec, key_vec;

    assign acc_vec = {r_acc[0], r_acc[1], r_acc[2], r_acc[3],
                      r_acc[4], r_acc[5], r_acc[6], r_acc[7]};

    always_comb begin
        for (int i = 0; i < 32; i++) begin
            key_vec[255 - 8 * i -: 8] = (pbkdf_pkg::VB_W'(i) < vb) ?
                                        acc_vec[255 - 8 * i -: 8] : 8'h00;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter_cfg   <= pbkdf_pkg::ITER_W'(1);
            r_dklen_cfg  <= pbkdf_pkg::DKLEN_W'(32);
            r_pw_len     <= '0;
            r_salt_len   <= '0;
            r_ovf        <= 1'b0;
            r_key_hashed <= 1'b0;
            r_blk        <= '0;
            r_pos        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    pbkdf_pkg::CFG_ITER:  r_iter_cfg  <= i_cfg_data[pbkdf_pkg::ITER_W-1:0];
                    pbkdf_pkg::CFG_DKLEN: r_dklen_cfg <= i_cfg_data[pbkdf_pkg::DKLEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.pw_wr) begin
                if (pw_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_pw_len <= r_pw_len + pbkdf_pkg::PW_LW'(1);
                end
            end
            if (i_cmd.salt_wr) begin
                if (salt_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_salt_len <= r_salt_len + pbkdf_pkg::SALT_LW'(1);
                end
            end
            if (i_cmd.clear) begin
                r_pw_len   <= '0;
                r_salt_len <= '0;
                r_ovf      <= 1'b0;
            end
            if (i_cmd.run_init) begin
                r_key_hashed <= 1'b0;
                r_blk        <= '0;
            end
            if (i_cmd.store && i_cmd.mode == pbkdf_pkg::M_KEY) begin
                r_key_hashed <= 1'b1;
            end
            if (i_cmd.blk_next) begin
                r_blk <= r_blk + pbkdf_pkg::BLK_W'(1);
            end
            if (i_cmd.h_start) begin
                r_pos <= '0;
            end else if (i_cmd.push) begin
                r_pos <= r_pos + POS_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hash state and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.h_start) begin
            unique case (i_cmd.mode)
                pbkdf_pkg::M_INNER1, pbkdf_pkg::M_INNERJ: r_chain <= r_inner_mid;
                pbkdf_pkg::M_OUTER:                       r_chain <= r_outer_mid;
                default:                                  r_chain <= pbkdf_pkg::SHA_IV;
            endcase
        end
        if (i_cmd.push) begin
            r_wv <= {r_wv[503:0], push_byte};
        end
        if (i_cmd.c_init) begin
            r_v <= r_chain;
        end
        if (i_cmd.c_round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            r_wv   <= {r_wv[479:0], new_w};
        end
        if (i_cmd.c_add) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= r_chain[i] + r_v[i];
            end
        end
        if (i_cmd.store) begin
            unique case (i_cmd.mode)
                pbkdf_pkg::M_IPAD: r_inner_mid <= r_chain;
                pbkdf_pkg::M_OPAD: r_outer_mid <= r_chain;
                pbkdf_pkg::M_OUTER: begin
                    r_u <= r_chain;
                    for (int i = 0; i < 8; i++) begin
                        r_acc[i] <= i_cmd.acc_first ? r_chain[i] : (r_acc[i] ^ r_chain[i]);
                    end
                end
                default: r_u <= r_chain;
            endcase
        end
        if (i_cmd.emit) begin
            if (i_cmd.emit_err) begin
                r_out_status <= 1'b1;
                r_out_blk    <= '0;
                r_out_vb     <= '0;
                r_out_last   <= 1'b1;
                for (int j = 0; j < 4; j++) begin
                    r_out_word[j] <= '0;
                end
            end else begin
                r_out_status <= 1'b0;
                r_out_blk    <= r_blk;
                r_out_vb     <= vb;
                r_out_last   <= last_blk;
                for (int j = 0; j < 4; j++) begin
                    r_out_word[j] <= key_vec[255 - 64 * j -: 64];
                end
            end
        end
    end

    assign o_sts.pw_long  = (r_pw_len > pbkdf_pkg::PW_LW'(64));
    assign o_sts.ovf      = r_ovf;
    assign o_sts.blk_full = (r_pos[5:0] == 6'd63);
    assign o_sts.msg_end  = (r_pos == end_pos);
    assign o_sts.last_blk = last_blk;
    assign o_sts.out_free = !r_out_valid || !i_stall;
    assign o_sts.iters    = iters;

    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_block_index = r_out_blk;
    assign o_key_word0   = r_out_word[0];
    assign o_key_word1   = r_out_word[1];
    assign o_key_word2   = r_out_word[2];
    assign o_key_word3   = r_out_word[3];
    assign o_valid_bytes = r_out_vb;
    assign o_last        = r_out_last;

endmodule
